// ===== hw/rtl/grid_trilinear_sampler_defines.svh =====
// Assertion macros shared by the grid trilinear sampler RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef GRID_TRILINEAR_SAMPLER_DEFINES_SVH
`define GRID_TRILINEAR_SAMPLER_DEFINES_SVH

// same-cycle implication
`define GTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gts_pkg.sv =====
// Package of types, constants and helper functions for the grid trilinear sampler.
`timescale 1ns / 1ps
`default_nettype none

package gts_pkg;

    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;

    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd5;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [CNT_W-1:0] AXIS_LAST = 4'd3;
    localparam logic [CNT_W-1:0] READ_LAST = 4'd8;
    localparam logic [CNT_W-1:0] LERP_LAST = 4'd11;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] node_x;
        logic [IDX_W-1:0] node_y;
        logic [IDX_W-1:0] node_z;
        logic [VAL_W-1:0] node_value;
        logic [VAL_W-1:0] pos_x;
        logic [VAL_W-1:0] pos_y;
        logic [VAL_W-1:0] pos_z;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] step;
    } lstep_t;

    typedef struct packed {
        logic       load_pos;
        logic       wr_item;
        logic       clr_step;
        logic       ax_mul;
        logic [1:0] ax_mul_sel;
        logic       ax_fold;
        logic [1:0] ax_fold_sel;
        logic       rd_en;
        logic [2:0] rd_corner;
        logic       cap_en;
        logic [2:0] cap_slot;
        lstep_t     op_rd;
        logic       lerp_mul;
        lstep_t     lerp_fin;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } status_t;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_AXIS  = 6'b000100,
        S_READ  = 6'b001000,
        S_LERP  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    function automatic logic [VAL_W-1:0] sat32(input logic signed [49:0] v);
        logic [VAL_W-1:0] r;
        if (v > 50'sd2147483647) begin
            r = VAL_MAX;
        end else if (v < -50'sd2147483648) begin
            r = VAL_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Slot file: corners at {dz,dy,dx}; each lerp writes back into its a slot.
    function automatic logic [2:0] lerp_a(input logic [2:0] step);
        logic [2:0] r;
        unique case (step)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd0;
            3'd5:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lerp_b(input logic [2:0] step);
        logic [2:0] r;
        unique case (step)
            3'd0:    r = 3'd1;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd5;
            3'd3:    r = 3'd7;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd6;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] lerp_axis(input logic [2:0] step);
        logic [1:0] r;
        unique case (step)
            3'd0, 3'd1, 3'd2, 3'd3: r = AX_X;
            3'd4, 3'd5:             r = AX_Y;
            default:                r = AX_Z;
        endcase
        return r;
    endfunction

    // Operand read schedule; the multiply follows in the next cycle, then the writeback.
    function automatic lstep_t lerp_sched(input logic [CNT_W-1:0] cnt);
        lstep_t r;
        r = '0;
        unique case (cnt)
            4'd0:    r = '{valid: 1'b1, step: 3'd0};
            4'd1:    r = '{valid: 1'b1, step: 3'd1};
            4'd2:    r = '{valid: 1'b1, step: 3'd2};
            4'd3:    r = '{valid: 1'b1, step: 3'd3};
            4'd4:    r = '{valid: 1'b1, step: 3'd4};
            4'd6:    r = '{valid: 1'b1, step: 3'd5};
            4'd9:    r = '{valid: 1'b1, step: 3'd6};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gts_if.sv =====
// Channel interfaces of the grid trilinear sampler: request, result and config write.
`timescale 1ns / 1ps
`default_nettype none

interface gts_in_if import gts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [IDX_W-1:0]        node_x;
    logic [IDX_W-1:0]        node_y;
    logic [IDX_W-1:0]        node_z;
    logic signed [VAL_W-1:0] node_value;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;

    modport source (
        output valid, opcode, node_x, node_y, node_z, node_value, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, node_x, node_y, node_z, node_value, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

interface gts_out_if import gts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

interface gts_cfg_if import gts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/grid_trilinear_sampler.sv =====
// Top level of the grid trilinear sampler: 3D distance grid with trilinear lookup.
//
// Channels: req carries items (opcode 0 writes one node value, opcode 1 queries a
// point in signed Q16.16); rsp returns one distance per query, none per write;
// cfg writes the origin and reciprocal spacing registers and is always ready.
// An item moves when valid and ready are both high at a rising clock edge.
// After reset the node memory is swept to the largest positive value, one node a cycle,
// over all GRID_X*GRID_Y*GRID_Z nodes (4096 by default); req.ready stays low meanwhile.
// After a write item req.ready stays high.
// A query: axis scaling, then reading the eight corners from the node memory, then
// the lerp steps on the shared lerp multiplier, then the result is loaded into the
// output register. req.ready returns the cycle after the load, so no new item is
// accepted while a query is in progress.
// The output register holds the result while rsp.ready is low; the next item is
// accepted meanwhile, and a following query stalls only at its final load.
`timescale 1ns / 1ps
`default_nettype none

module grid_trilinear_sampler import gts_pkg::*; #(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gts_in_if.sink     req,
    gts_out_if.source  rsp,
    gts_cfg_if.sink    cfg
);

    cmd_t             cmd;
    status_t          status;
    item_t            item;
    logic             ctrl_in_ready;
    logic             ctrl_out_valid;
    logic [VAL_W-1:0] dp_distance;

    assign item.opcode     = req.opcode;
    assign item.node_x     = req.node_x;
    assign item.node_y     = req.node_y;
    assign item.node_z     = req.node_z;
    assign item.node_value = req.node_value;
    assign item.pos_x      = req.pos_x;
    assign item.pos_y      = req.pos_y;
    assign item.pos_z      = req.pos_z;

    assign req.ready    = ctrl_in_ready;
    assign rsp.valid    = ctrl_out_valid;
    assign rsp.distance = dp_distance;
    assign cfg.ready    = 1'b1;

    gts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (item.opcode),
        .in_ready  (ctrl_in_ready),
        .out_valid (ctrl_out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    gts_dp #(
        .GX (GRID_X),
        .GY (GRID_Y),
        .GZ (GRID_Z)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .distance  (dp_distance)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gts_ctrl.sv =====
// Controller state machine of the grid trilinear sampler.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_trilinear_sampler_defines.svh"

module gts_ctrl import gts_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_opcode,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_opcode == OP_QUERY)
                    begin
                        cmd.load_pos = 1'b1;
                        state_next   = S_AXIS;
                        cnt_next     = '0;
                    end else begin
                        cmd.wr_item = 1'b1;
                    end
                end
            end
            S_AXIS:
            begin
                cmd.ax_mul      = (cnt_reg < AXIS_LAST);
                cmd.ax_mul_sel  = cnt_reg[1:0];
                cmd.ax_fold     = (cnt_reg != '0);
                cmd.ax_fold_sel = cnt_reg[1:0] - 2'd1;
                if (cnt_reg == AXIS_LAST)
                begin
                    state_next = S_READ;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_READ:
            begin
                cmd.rd_en     = (cnt_reg < READ_LAST);
                cmd.rd_corner = cnt_reg[2:0];
                cmd.cap_en    = (cnt_reg != '0);
                cmd.cap_slot  = cnt_reg[2:0] - 3'd1;
                if (cnt_reg == READ_LAST)
                begin
                    state_next = S_LERP;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_LERP:
            begin
                cmd.op_rd    = lerp_sched(cnt_reg);
                cmd.lerp_mul = lerp_sched(cnt_reg - 4'd1).valid;
                cmd.lerp_fin = lerp_sched(cnt_reg - 4'd2);
                if (cnt_reg == LERP_LAST)
                begin
                    state_next = S_DONE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `GTS_ASSERT_NXT(a_query_start, in_accept && in_opcode == OP_QUERY, state_reg == S_AXIS && cnt_reg == '0, "query did not start axis phase")
    `GTS_ASSERT_NXT(a_lerp_done, state_reg == S_LERP && cnt_reg == LERP_LAST, state_reg == S_DONE, "lerp phase did not finish")
    `GTS_ASSERT_IMP(a_read_bound, state_reg == S_READ, cnt_reg <= READ_LAST, "read counter overran")
    `GTS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "unread result overwritten")

endmodule

`default_nettype wire

// ===== hw/rtl/gts_dp.sv =====
// Datapath of the grid trilinear sampler: config, node memory, axis scaling and lerp unit.
`timescale 1ns / 1ps
`default_nettype none

module gts_dp import gts_pkg::*; #(
    parameter int GX = GRID_X_DEF,
    parameter int GY = GRID_Y_DEF,
    parameter int GZ = GRID_Z_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  item_t                item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output logic [VAL_W-1:0]     distance
);

    localparam int NODES = GX * GY * GZ;
    localparam int AW    = $clog2(NODES);
    localparam int XW    = $clog2(GX);
    localparam int YW    = $clog2(GY);
    localparam int ZW    = $clog2(GZ);

    // configuration
    logic [VAL_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [VAL_W-1:0] inv_x_reg, inv_y_reg, inv_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_x_reg    <= 32'h0001_0000;
            inv_y_reg    <= 32'h0001_0000;
            inv_z_reg    <= 32'h0001_0000;
        end else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                REG_INV_X:    inv_x_reg    <= cfg_data;
                REG_INV_Y:    inv_y_reg    <= cfg_data;
                REG_INV_Z:    inv_z_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // query point
    logic [VAL_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_pos)
        begin
            pos_x_reg <= item.pos_x;
            pos_y_reg <= item.pos_y;
            pos_z_reg <= item.pos_z;
        end
    end

    // axis scaling: f = floor((pos - origin) * inv / 2^16)
    logic [VAL_W-1:0]    mul_pos, mul_org, mul_inv;
    logic signed [32:0]  ax_diff;
    logic signed [65:0]  ax_prod;
    logic signed [48:0]  f_reg;

    always_comb
    begin
        unique case (cmd.ax_mul_sel)
            AX_Y:
            begin
                mul_pos = pos_y_reg;
                mul_org = origin_y_reg;
                mul_inv = inv_y_reg;
            end
            AX_Z:
            begin
                mul_pos = pos_z_reg;
                mul_org = origin_z_reg;
                mul_inv = inv_z_reg;
            end
            default:
            begin
                mul_pos = pos_x_reg;
                mul_org = origin_x_reg;
                mul_inv = inv_x_reg;
            end
        endcase
    end

    assign ax_diff = {mul_pos[31], mul_pos} - {mul_org[31], mul_org};
    assign ax_prod = ax_diff * $signed({1'b0, mul_inv});

    always_ff @(posedge clk)
    begin
        if (cmd.ax_mul)
        begin
            f_reg <= ax_prod[64:16];
        end
    end

    // fold: clamp cell index, saturate fraction
    logic signed [32:0]  cell_raw, cell_lim, cell_cl;
    logic signed [48:0]  t_wide;
    logic [VAL_W-1:0]    t_sat;
    logic [XW-1:0]       cell_x_reg;
    logic [YW-1:0]       cell_y_reg;
    logic [ZW-1:0]       cell_z_reg;
    logic [VAL_W-1:0]    t_reg [3];

    assign cell_raw = f_reg[48:16];

    always_comb
    begin
        unique case (cmd.ax_fold_sel)
            AX_Y:    cell_lim = 33'(GY - 2);
            AX_Z:    cell_lim = 33'(GZ - 2);
            default: cell_lim = 33'(GX - 2);
        endcase
        priority if (cell_raw < 0)
        begin
            cell_cl = '0;
        end else if (cell_raw > cell_lim)
        begin
            cell_cl = cell_lim;
        end else begin
            cell_cl = cell_raw;
        end
    end

    assign t_wide = f_reg - $signed({cell_cl, 16'h0000});
    assign t_sat  = sat32(50'(t_wide));

    always_ff @(posedge clk)
    begin
        if (cmd.ax_fold)
        begin
            t_reg[cmd.ax_fold_sel] <= t_sat;
            unique case (cmd.ax_fold_sel)
                AX_Y:    cell_y_reg <= cell_cl[YW-1:0];
                AX_Z:    cell_z_reg <= cell_cl[ZW-1:0];
                default: cell_x_reg <= cell_cl[XW-1:0];
            endcase
        end
    end

    // node memory with clearing pass
    logic [VAL_W-1:0] node_mem [NODES];
    logic [AW-1:0]    clr_cnt_reg;
    logic [AW-1:0]    wr_addr, rd_addr, mem_waddr;
    logic [VAL_W-1:0] mem_wdata, rd_data_reg;
    logic             wr_ok, mem_we;
    logic [XW-1:0]    cx;
    logic [YW-1:0]    cy;
    logic [ZW-1:0]    cz;

    assign wr_ok = ({5'd0, item.node_x} < 9'(GX)) && ({5'd0, item.node_y} < 9'(GY))
                && ({5'd0, item.node_z} < 9'(GZ));
    assign wr_addr = AW'(item.node_z) * AW'(GX * GY) + AW'(item.node_y) * AW'(GX)
                   + AW'(item.node_x);

    assign cx = cell_x_reg + XW'(cmd.rd_corner[0]);
    assign cy = cell_y_reg + YW'(cmd.rd_corner[1]);
    assign cz = cell_z_reg + ZW'(cmd.rd_corner[2]);
    assign rd_addr = AW'(cz) * AW'(GX * GY) + AW'(cy) * AW'(GX) + AW'(cx);

    assign mem_we    = cmd.clr_step || (cmd.wr_item && wr_ok);
    assign mem_waddr = cmd.clr_step ? clr_cnt_reg : wr_addr;
    assign mem_wdata = cmd.clr_step ? VAL_MAX : item.node_value;

    assign status.clr_last = (clr_cnt_reg == AW'(NODES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // lerp unit: operand read, multiply, writeback
    logic [VAL_W-1:0]        slot_reg [8];
    logic signed [VAL_W-1:0] op_a_reg, op_b_reg, op_t_reg, a2_reg;
    logic signed [32:0]      op_dba;
    logic signed [64:0]      prod_reg;
    logic signed [48:0]      prod_sh;
    logic signed [49:0]      lerp_sum;
    logic [VAL_W-1:0]        fin_val, res_reg, distance_reg;

    assign op_dba   = {op_b_reg[31], op_b_reg} - {op_a_reg[31], op_a_reg};
    assign prod_sh  = prod_reg[64:16];
    assign lerp_sum = 50'(a2_reg) + 50'(prod_sh);
    assign fin_val  = sat32(lerp_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            slot_reg[cmd.cap_slot] <= rd_data_reg;
        end else if (cmd.lerp_fin.valid)
        begin
            slot_reg[lerp_a(cmd.lerp_fin.step)] <= fin_val;
        end
        if (cmd.op_rd.valid)
        begin
            op_a_reg <= slot_reg[lerp_a(cmd.op_rd.step)];
            op_b_reg <= slot_reg[lerp_b(cmd.op_rd.step)];
            op_t_reg <= t_reg[lerp_axis(cmd.op_rd.step)];
        end
        if (cmd.lerp_mul)
        begin
            prod_reg <= op_dba * op_t_reg;
            a2_reg   <= op_a_reg;
        end
        if (cmd.lerp_fin.valid)
        begin
            res_reg <= fin_val;
        end
        if (cmd.out_load)
        begin
            distance_reg <= res_reg;
        end
    end

    assign distance = distance_reg;

endmodule

`default_nettype wire

// ===== test/grid_trilinear_sampler_tb.sv =====
// Self-checking testbench for grid_trilinear_sampler: node writes, trilinear queries, config.
`timescale 1ns / 1ps

module grid_trilinear_sampler_tb;
    import gts_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int GRID_N       = 16;
    localparam int NODE_COUNT   = GRID_N * GRID_N * GRID_N;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_OFF     = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 130;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gts_in_if  req ();
    gts_out_if rsp ();
    gts_cfg_if cfg ();

    grid_trilinear_sampler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #CLK_HALF clk = ~clk;

    logic signed [VAL_W-1:0] node_mem [NODE_COUNT];
    logic signed [VAL_W-1:0] grid_org [3];
    logic [VAL_W-1:0]        grid_inv [3];
    logic [VAL_W-1:0]        expected_distance [$];

    int mismatches  = 0;
    int cycles      = 0;
    int hold_cycles = 0;
    int sink_left   = 0;
    bit sink_on     = 1'b1;
    bit sink_quiet  = 1'b0;
    bit src_quiet   = 1'b0;

    // ---------------- distance predictor ----------------

    function automatic longint sat_s32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic void locate(input logic [VAL_W-1:0] pos, input logic [1:0] ax,
                                   output int cell_idx, output longint frac);
        longint             diff;
        logic signed [67:0] prod;
        longint             f;
        longint             c;
        diff = longint'($signed(pos)) - longint'(grid_org[ax]);
        prod = diff * $signed({36'd0, grid_inv[ax]});
        prod = prod >>> 16;
        f    = longint'(prod[63:0]);
        c    = f >>> 16;
        if (c < 0) c = 0;
        if (c > GRID_N - 2) c = GRID_N - 2;
        cell_idx = int'(c);
        frac     = sat_s32(f - c * 65536);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint t);
        return sat_s32(a + (((b - a) * t) >>> 16));
    endfunction

    function automatic longint node_at(input int x, input int y, input int z);
        return longint'(node_mem[(z * GRID_N + y) * GRID_N + x]);
    endfunction

    function automatic logic [VAL_W-1:0] grid_distance(input logic [VAL_W-1:0] px,
                                                       input logic [VAL_W-1:0] py,
                                                       input logic [VAL_W-1:0] pz);
        int     i, j, k;
        longint tx, ty, tz, c00, c01, c10, c11, c0, c1;
        locate(px, AX_X, i, tx);
        locate(py, AX_Y, j, ty);
        locate(pz, AX_Z, k, tz);
        c00 = blend(node_at(i, j, k),         node_at(i + 1, j, k),         tx);
        c01 = blend(node_at(i, j, k + 1),     node_at(i + 1, j, k + 1),     tx);
        c10 = blend(node_at(i, j + 1, k),     node_at(i + 1, j + 1, k),     tx);
        c11 = blend(node_at(i, j + 1, k + 1), node_at(i + 1, j + 1, k + 1), tx);
        c0  = blend(c00, c10, ty);
        c1  = blend(c01, c11, ty);
        return 32'(blend(c0, c1, tz));
    endfunction

    function automatic void absorb_item(input item_t it);
        if (it.opcode == OP_WRITE)
            node_mem[(int'(it.node_z) * GRID_N + int'(it.node_y)) * GRID_N
                     + int'(it.node_x)] = it.node_value;
        else
            expected_distance.push_back(grid_distance(it.pos_x, it.pos_y, it.pos_z));
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic item_t node_write(input int x, input int y, input int z,
                                         input logic [VAL_W-1:0] value);
        item_t it;
        it.opcode     = OP_WRITE;
        it.node_x     = IDX_W'(x);
        it.node_y     = IDX_W'(y);
        it.node_z     = IDX_W'(z);
        it.node_value = value;
        it.pos_x      = $urandom;
        it.pos_y      = $urandom;
        it.pos_z      = $urandom;
        return it;
    endfunction

    function automatic item_t point_query(input logic [VAL_W-1:0] px,
                                          input logic [VAL_W-1:0] py,
                                          input logic [VAL_W-1:0] pz);
        item_t it;
        it.opcode     = OP_QUERY;
        it.node_x     = IDX_W'($urandom);
        it.node_y     = IDX_W'($urandom);
        it.node_z     = IDX_W'($urandom);
        it.node_value = $urandom;
        it.pos_x      = px;
        it.pos_y      = py;
        it.pos_z      = pz;
        return it;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    // grid coordinate in Q16.16, mostly inside the working region
    function automatic longint grid_coord(input int base);
        if ($urandom_range(0, 7) == 0)
            return longint'($urandom_range(0, 20 * 65536)) - 2 * 65536;
        return longint'(base) * 65536 + longint'($urandom_range(0, 3 * 65536));
    endfunction

    function automatic logic [VAL_W-1:0] pos_for(input longint g, input logic [1:0] ax);
        longint off;
        if (grid_inv[ax] == '0) return $urandom;
        off = (g * 65536) / longint'(grid_inv[ax]);
        return 32'(longint'(grid_org[ax]) + off);
    endfunction

    function automatic item_t random_item(input int bx, input int by, input int bz);
        item_t it;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            it.opcode     = 1'($urandom_range(0, 1));
            it.node_x     = IDX_W'($urandom);
            it.node_y     = IDX_W'($urandom);
            it.node_z     = IDX_W'($urandom);
            it.node_value = $urandom;
            it.pos_x      = $urandom;
            it.pos_y      = $urandom;
            it.pos_z      = $urandom;
        end
        else if (roll < 50)
        begin
            it = node_write(bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                            bz + $urandom_range(0, 3), random_value());
        end
        else
        begin
            it = point_query(pos_for(grid_coord(bx), AX_X), pos_for(grid_coord(by), AX_Y),
                             pos_for(grid_coord(bz), AX_Z));
        end
        return it;
    endfunction

    // ---------------- channel tasks (entered and left at a falling edge) ----------------

    task automatic send_item(input item_t it);
        req.valid      = 1'b1;
        req.opcode     = it.opcode;
        req.node_x     = it.node_x;
        req.node_y     = it.node_y;
        req.node_z     = it.node_z;
        req.node_value = it.node_value;
        req.pos_x      = it.pos_x;
        req.pos_y      = it.pos_y;
        req.pos_z      = it.pos_z;
        do @(posedge clk); while (!req.ready);
        absorb_item(it);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic sender_gap();
        if (!src_quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_ORIGIN_X: grid_org[AX_X] = data;
            REG_ORIGIN_Y: grid_org[AX_Y] = data;
            REG_ORIGIN_Z: grid_org[AX_Z] = data;
            REG_INV_X:    grid_inv[AX_X] = data;
            REG_INV_Y:    grid_inv[AX_Y] = data;
            REG_INV_Z:    grid_inv[AX_Z] = data;
            default:      ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_distance.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_grid(input logic [VAL_W-1:0] ox, input logic [VAL_W-1:0] oy,
                            input logic [VAL_W-1:0] oz, input logic [VAL_W-1:0] ix,
                            input logic [VAL_W-1:0] iy, input logic [VAL_W-1:0] iz);
        wait_idle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_X, ix);
        write_reg(REG_INV_Y, iy);
        write_reg(REG_INV_Z, iz);
    endtask

    // ---------------- tests ----------------

    // untouched store: every blend of equal corners
    task automatic test_reset_grid();
        send_item(point_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(point_query(32'h000F_0000, 32'h000F_0000, 32'h000F_0000));
        send_item(point_query(32'h7FFF_FFFF, 32'h0003_8000, 32'h8000_0000));
        send_item(point_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0007_4000));
    endtask

    task automatic test_node_extremes();
        send_item(node_write(0, 0, 0, VAL_MIN));
        send_item(node_write(1, 0, 0, VAL_MAX));
        send_item(node_write(0, 1, 0, 32'h0000_0000));
        send_item(node_write(1, 1, 0, 32'hFFFF_FFFF));
        send_item(node_write(0, 0, 1, 32'h0001_0000));
        send_item(node_write(1, 1, 1, 32'hFFFD_0000));
        send_item(node_write(15, 15, 15, VAL_MIN));
        send_item(node_write(14, 15, 15, 32'h1234_5678));
        send_item(point_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        send_item(point_query(32'h0000_4000, 32'h0000_C000, 32'h0000_0000));
        send_item(point_query(32'h000F_0000, 32'h000F_0000, 32'h000F_0000));
        send_item(point_query(32'h000E_8000, 32'h000F_0000, 32'h000F_0000));
        // extrapolation below and above the grid, then far out on both sides
        send_item(point_query(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(point_query(32'h0011_0000, 32'h0010_8000, 32'h000F_C000));
        send_item(point_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(point_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    endtask

    task automatic test_spacing_extremes();
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_8000);
        send_item(point_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_C000));
        send_item(point_query(32'h0001_0000, 32'h8000_0001, 32'hFFFF_8000));
        wait_idle();
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        send_item(point_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000));
    endtask

    task automatic test_backpressure();
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        for (int n = 0; n < 8; n++)
            send_item(node_write($urandom_range(2, 5), $urandom_range(2, 5),
                                 $urandom_range(2, 5), random_value()));
        @(posedge clk);
        hold_cycles = HOLD_OFF;
        @(negedge clk);
        for (int n = 0; n < 8; n++)
            send_item(point_query(pos_for(grid_coord(2), AX_X), pos_for(grid_coord(2), AX_Y),
                                  pos_for(grid_coord(2), AX_Z)));
        wait_idle();
    endtask

    task automatic configure_phase(input int phase);
        case (phase)
            0: set_grid(32'hFFFD_8000, 32'h0001_4000, 32'h0003_0000,
                        32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
            2: set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                        32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000);
            3: set_grid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default:
                set_grid(32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
                         32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
                         32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
                         $urandom_range(32'h4000, 32'h40000),
                         $urandom_range(32'h4000, 32'h40000),
                         $urandom_range(32'h4000, 32'h40000));
        endcase
        if ($urandom_range(0, 1) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    endtask

    task automatic test_random_phases();
        int bx, by, bz;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            configure_phase(phase);
            if (phase == PHASES - 1)
            begin
                src_quiet  = 1'b1;
                sink_quiet = 1'b1;
            end
            bx = $urandom_range(0, 12);
            by = $urandom_range(0, 12);
            bz = $urandom_range(0, 12);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item(bx, by, bz));
                sender_gap();
            end
        end
    endtask

    // ---------------- result side ----------------

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp.ready = 1'b0;
            hold_cycles--;
        end
        else if (sink_quiet)
        begin
            rsp.ready = 1'b1;
        end
        else
        begin
            if (sink_left == 0)
            begin
                sink_on   = ($urandom_range(0, 2) != 0);
                sink_left = $urandom_range(1, 9);
            end
            rsp.ready = sink_on;
            sink_left--;
        end
    end

    always @(posedge clk)
    begin
        logic [VAL_W-1:0] want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_distance.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected distance item: got %h", rsp.distance);
            end
            else
            begin
                want = expected_distance.pop_front();
                if (rsp.distance !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("distance mismatch: expected %h got %h", want, rsp.distance);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("grid_trilinear_sampler regression: fail");
            $finish;
        end
    end

    initial
    begin
        req.valid      = 1'b0;
        req.opcode     = OP_WRITE;
        req.node_x     = '0;
        req.node_y     = '0;
        req.node_z     = '0;
        req.node_value = '0;
        req.pos_x      = '0;
        req.pos_y      = '0;
        req.pos_z      = '0;
        rsp.ready      = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_ORIGIN_X;
        cfg.data       = '0;
        for (int n = 0; n < NODE_COUNT; n++) node_mem[n] = VAL_MAX;
        for (int a = 0; a < 3; a++)
        begin
            grid_org[a] = '0;
            grid_inv[a] = 32'h0001_0000;
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_grid();
        test_node_extremes();
        test_spacing_extremes();
        test_backpressure();
        test_random_phases();

        wait_idle();
        if (mismatches == 0)
            $display("grid_trilinear_sampler regression: pass");
        else
            $display("grid_trilinear_sampler regression: fail");
        $finish;
    end

endmodule
